>>> hdl/ispm_pkg.sv
`timescale 1ns / 1ps

package ispm_pkg;

  // Field widths fixed by the register map and the payload
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned SENSOR_NO_W = 5;
  localparam int unsigned MASK_BITS   = 16;
  localparam int unsigned REG_IDX_W   = 3;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned FEAT_W      = 2;

  localparam logic [WORD_W-1:0]  TICK_MAX  = 16'hFFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
  localparam logic [WORD_W-1:0]  PRESSURE_MIN_LIMIT = 16'd1;
  localparam logic [WORD_W-1:0]  CHECK_TICKS_RESET  = 16'd10;

  // Register indexes on the configuration port
  localparam logic [REG_IDX_W-1:0] REG_USE_MODE      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SENSORS_ALL   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CHECK_TICKS   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE_MASK   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_NORMAL_MASK   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_HEAVY_MASK    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PRESSURE_LIM  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_FEATURES      = 3'd7;

  // Operating modes
  localparam logic [MODE_W-1:0] MODE_DISABLED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CONTROL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ENABLE   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ALL      = 2'd3;

  // Feature enable bits
  localparam int unsigned FEAT_PRESSURE = 0;
  localparam int unsigned FEAT_VALVE    = 1;

  // One entry of the per-sensor timer store
  typedef struct packed {
    logic              armed;
    logic [WORD_W-1:0] ticks;
  } sensor_state_t;

  // Outcome of evaluating one sensor
  typedef struct packed {
    logic          write;
    sensor_state_t next;
    logic          fire_heavy;
    logic          fire_light;
  } sensor_eval_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    logic [COUNT_W-1:0] r;
    r = (c < COUNT_MAX) ? c + COUNT_W'(1) : c;
    return r;
  endfunction

endpackage

>>> hdl/ispm_state_mem.sv
`timescale 1ns / 1ps

module ispm_state_mem #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   clear_all,
  input  logic                   rd_en,
  input  logic [ADDR_W-1:0]      rd_addr,
  output ispm_pkg::sensor_state_t rd_data,
  input  logic                   wr_en,
  input  logic [ADDR_W-1:0]      wr_addr,
  input  ispm_pkg::sensor_state_t wr_data
);

  ispm_pkg::sensor_state_t mem [DEPTH];
  logic [DEPTH-1:0]        valid;
  ispm_pkg::sensor_state_t rd_raw;
  logic                    rd_hit;

  // Hold the timer words; written and read one entry a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // Track which entries hold a live value; a cleared entry reads as zero
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_hit ? rd_raw : '0;

endmodule

>>> hdl/ispm_sensor_eval.sv
`timescale 1ns / 1ps

module ispm_sensor_eval (
  input  ispm_pkg::sensor_state_t       cur,
  input  logic                          checked,
  input  logic                          level,
  input  logic                          normal,
  input  logic                          heavy,
  input  logic [ispm_pkg::WORD_W-1:0]   check_ticks,
  output ispm_pkg::sensor_eval_t        res
);

  logic [ispm_pkg::WORD_W-1:0] ticks_new;

  // Arm at zero, then count up with saturation
  always_comb begin
    if (!cur.armed) begin
      ticks_new = '0;
    end else if (cur.ticks < ispm_pkg::TICK_MAX) begin
      ticks_new = cur.ticks + ispm_pkg::WORD_W'(1);
    end else begin
      ticks_new = cur.ticks;
    end
  end

  // Decide write-back and firing for one sensor
  always_comb begin
    res = '0;
    if (checked) begin
      res.write = 1'b1;
      if (level != normal) begin
        if (ticks_new >= check_ticks) begin
          res.fire_heavy = heavy;
          res.fire_light = !heavy;
        end else begin
          res.next.armed = 1'b1;
          res.next.ticks = ticks_new;
        end
      end
    end
  end

endmodule

>>> hdl/interlock_sensor_persistence_monitor_unit.sv
`timescale 1ns / 1ps

// Interlock sensor persistence monitor. Each request is one 0.1 s tick with the
// sensor levels, the differential pressure and the valve-closed flag; each tick
// gives exactly one result. The per-sensor timers live in a memory with one
// read port, one write port and a registered read, walked one sensor a cycle
// through a read / evaluate / write-back pipe. The next request is taken while
// the last result still waits at the output register. Timers are cleared at once
// by valid bits, so there is no clearing pass after reset. The user must write
// configuration through cfg_we, cfg_index and cfg_data only while no tick is in
// flight; the block itself does not enforce this.
module interlock_sensor_persistence_monitor_unit #(
  parameter int unsigned SENSORS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ispm_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [ispm_pkg::WORD_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ispm_pkg::WORD_W-1:0]       sensor_bits,
  input  logic [ispm_pkg::WORD_W-1:0]       diff_pressure,
  input  logic                              valves_all_closed,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              heavy_active,
  output logic                              light_active,
  output logic [ispm_pkg::WORD_W-1:0]       heavy_fired,
  output logic [ispm_pkg::WORD_W-1:0]       light_fired,
  output logic [ispm_pkg::COUNT_W-1:0]      heavy_count,
  output logic [ispm_pkg::COUNT_W-1:0]      light_count,
  output logic                              pressure_error,
  output logic                              valve_alarm
);

  localparam int unsigned IW = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int unsigned CW = $clog2(SENSORS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

  // Configuration registers
  logic [ispm_pkg::MODE_W-1:0] use_mode;
  logic                        sensors_all_enable;
  logic [ispm_pkg::WORD_W-1:0] check_ticks;
  logic [ispm_pkg::WORD_W-1:0] enable_mask;
  logic [ispm_pkg::WORD_W-1:0] normal_mask;
  logic [ispm_pkg::WORD_W-1:0] heavy_mask;
  logic [ispm_pkg::WORD_W-1:0] pressure_low_limit;
  logic [ispm_pkg::FEAT_W-1:0] feature_enables;

  // Sequencer and tick registers
  state_t                       state;
  logic [CW-1:0]                rd_cnt;
  logic                         proc_valid;
  logic [IW-1:0]                proc_idx;
  logic                         tick_off;
  logic [ispm_pkg::WORD_W-1:0]  tick_bits;
  logic [ispm_pkg::WORD_W-1:0]  tick_press;
  logic                         tick_closed;
  logic [ispm_pkg::WORD_W-1:0]  acc_hfired;
  logic [ispm_pkg::WORD_W-1:0]  acc_lfired;
  logic [ispm_pkg::COUNT_W-1:0] acc_hcount;
  logic [ispm_pkg::COUNT_W-1:0] acc_lcount;
  logic                         heavy_flag;
  logic                         light_flag;
  logic                         pressure_flag;

  logic                          disabled;
  logic                          masked;
  logic                          accept;
  logic                          rd_en;
  logic                          out_free;
  logic [ispm_pkg::SENSOR_NO_W-1:0] sensor_no;
  logic                          in_range;
  logic [3:0]                    bit_sel;
  logic                          b_enable;
  logic                          b_level;
  logic                          b_normal;
  logic                          b_heavy;
  ispm_pkg::sensor_state_t       rd_data;
  ispm_pkg::sensor_eval_t        eval;
  logic [ispm_pkg::WORD_W-1:0]   fire_bit;
  logic                          p_err;
  logic                          p_next;
  logic                          v_alarm;
  logic [ispm_pkg::COUNT_W-1:0]  h_fin;
  logic [ispm_pkg::COUNT_W-1:0]  h_mid;

  assign disabled = (use_mode == ispm_pkg::MODE_DISABLED) ||
                    (use_mode == ispm_pkg::MODE_CONTROL && !sensors_all_enable);
  assign masked   = use_mode inside {ispm_pkg::MODE_CONTROL, ispm_pkg::MODE_ENABLE};
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign rd_en    = (state == ST_WALK) && (rd_cnt < CW'(SENSORS));
  assign out_free = !out_valid || out_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      use_mode           <= ispm_pkg::MODE_DISABLED;
      sensors_all_enable <= 1'b0;
      check_ticks        <= ispm_pkg::CHECK_TICKS_RESET;
      enable_mask        <= '0;
      normal_mask        <= '0;
      heavy_mask         <= '0;
      pressure_low_limit <= '0;
      feature_enables    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ispm_pkg::REG_USE_MODE:     use_mode <= cfg_data[ispm_pkg::MODE_W-1:0];
        ispm_pkg::REG_SENSORS_ALL:  sensors_all_enable <= cfg_data[0];
        ispm_pkg::REG_CHECK_TICKS:  check_ticks <= cfg_data;
        ispm_pkg::REG_ENABLE_MASK:  enable_mask <= cfg_data;
        ispm_pkg::REG_NORMAL_MASK:  normal_mask <= cfg_data;
        ispm_pkg::REG_HEAVY_MASK:   heavy_mask <= cfg_data;
        ispm_pkg::REG_PRESSURE_LIM: pressure_low_limit <= cfg_data;
        ispm_pkg::REG_FEATURES:     feature_enables <= cfg_data[ispm_pkg::FEAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Timer store
  ispm_state_mem #(
    .DEPTH  (SENSORS),
    .ADDR_W (IW)
  ) u_mem (
    .clk       (clk),
    .rst       (rst),
    .clear_all (accept && disabled),
    .rd_en     (rd_en),
    .rd_addr   (rd_cnt[IW-1:0]),
    .rd_data   (rd_data),
    .wr_en     (proc_valid && eval.write),
    .wr_addr   (proc_idx),
    .wr_data   (eval.next)
  );

  // Pick this sensor's mask and level bits; sensors past the masks read as zero
  assign sensor_no = ispm_pkg::SENSOR_NO_W'(proc_idx);
  assign in_range  = (sensor_no < ispm_pkg::SENSOR_NO_W'(ispm_pkg::MASK_BITS));
  assign bit_sel   = sensor_no[3:0];
  assign b_enable  = in_range && enable_mask[bit_sel];
  assign b_level   = in_range && tick_bits[bit_sel];
  assign b_normal  = in_range && normal_mask[bit_sel];
  assign b_heavy   = in_range && heavy_mask[bit_sel];
  assign fire_bit  = in_range ? (ispm_pkg::WORD_W'(1) << bit_sel) : '0;

  ispm_sensor_eval u_eval (
    .cur         (rd_data),
    .checked     (!masked || b_enable),
    .level       (b_level),
    .normal      (b_normal),
    .heavy       (b_heavy),
    .check_ticks (check_ticks),
    .res         (eval)
  );

  // Close the tick: pressure and valve checks on top of the sensor counts
  always_comb begin
    p_err   = (pressure_low_limit > ispm_pkg::PRESSURE_MIN_LIMIT) &&
              (tick_press < pressure_low_limit);
    p_next  = feature_enables[ispm_pkg::FEAT_PRESSURE] ? p_err : pressure_flag;
    v_alarm = feature_enables[ispm_pkg::FEAT_VALVE] && tick_closed;
    h_mid   = (feature_enables[ispm_pkg::FEAT_PRESSURE] && p_err) ?
              ispm_pkg::sat_inc(acc_hcount) : acc_hcount;
    h_fin   = v_alarm ? ispm_pkg::sat_inc(h_mid) : h_mid;
  end

  // Sequence the walk, accumulate, and hold the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      rd_cnt        <= '0;
      proc_valid    <= 1'b0;
      heavy_flag    <= 1'b0;
      light_flag    <= 1'b0;
      pressure_flag <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      proc_valid <= rd_en;
      if (out_valid && out_ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            rd_cnt <= '0;
            state  <= disabled ? ST_FINISH : ST_WALK;
          end
        end
        ST_WALK: begin
          if (rd_en) begin
            rd_cnt <= rd_cnt + CW'(1);
          end else if (!proc_valid) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
            if (tick_off) begin
              heavy_flag <= 1'b0;
              light_flag <= 1'b0;
            end else begin
              pressure_flag <= p_next;
              if (h_fin == '0 && acc_lcount == '0) begin
                heavy_flag <= 1'b0;
                light_flag <= 1'b0;
              end else begin
                if (h_fin != '0) begin
                  heavy_flag <= 1'b1;
                end
                if (acc_lcount != '0) begin
                  light_flag <= 1'b1;
                end
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Latch the request and run the per-tick accumulators
  always_ff @(posedge clk) begin
    if (accept) begin
      tick_off    <= disabled;
      tick_bits   <= sensor_bits;
      tick_press  <= diff_pressure;
      tick_closed <= valves_all_closed;
      acc_hfired  <= '0;
      acc_lfired  <= '0;
      acc_hcount  <= '0;
      acc_lcount  <= '0;
    end else if (proc_valid) begin
      if (eval.fire_heavy) begin
        acc_hfired <= acc_hfired | fire_bit;
        acc_hcount <= ispm_pkg::sat_inc(acc_hcount);
      end
      if (eval.fire_light) begin
        acc_lfired <= acc_lfired | fire_bit;
        acc_lcount <= ispm_pkg::sat_inc(acc_lcount);
      end
    end
    proc_idx <= rd_cnt[IW-1:0];
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      if (tick_off) begin
        heavy_fired <= '0;
        light_fired <= '0;
        heavy_count <= '0;
        light_count <= '0;
        valve_alarm <= 1'b0;
      end else begin
        heavy_fired <= acc_hfired;
        light_fired <= acc_lfired;
        heavy_count <= h_fin;
        light_count <= acc_lcount;
        valve_alarm <= v_alarm;
      end
    end
  end

  assign heavy_active   = heavy_flag;
  assign light_active   = light_flag;
  assign pressure_error = pressure_flag;

endmodule

>>> hdl/ispm_checker.sv
`timescale 1ns / 1ps

module ispm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          heavy_active,
  input logic                          light_active,
  input logic [ispm_pkg::WORD_W-1:0]   heavy_fired,
  input logic [ispm_pkg::WORD_W-1:0]   light_fired,
  input logic [ispm_pkg::COUNT_W-1:0]  heavy_count,
  input logic [ispm_pkg::COUNT_W-1:0]  light_count,
  input logic                          valve_alarm
);

  // Hold the result while it is stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(heavy_fired) &&
                                $stable(light_fired) && $stable(heavy_count))
    else $error("stalled result changed");

  // A sensor fires as heavy or as light, never both
  a_fired_disjoint: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heavy_fired & light_fired) == '0)
    else $error("sensor fired both heavy and light");

  // Light count matches the light fired mask
  a_light_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones(light_fired) == int'(light_count))
    else $error("light count disagrees with fired mask");

  // A quiet tick drops both interlock flags
  a_quiet_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && heavy_count == '0 && light_count == '0 |->
      !heavy_active && !light_active)
    else $error("flags held after a quiet tick");

  // A valve alarm counts as a heavy error
  a_valve_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid && valve_alarm |-> heavy_count != '0 && heavy_active)
    else $error("valve alarm not counted");

endmodule

bind interlock_sensor_persistence_monitor_unit ispm_checker u_ispm_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .heavy_active (heavy_active),
  .light_active (light_active),
  .heavy_fired  (heavy_fired),
  .light_fired  (light_fired),
  .heavy_count  (heavy_count),
  .light_count  (light_count),
  .valve_alarm  (valve_alarm)
);

>>> sim/interlock_sensor_persistence_monitor_unit_test.sv
`timescale 1ns / 1ps

module interlock_sensor_persistence_monitor_unit_test;

  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned PHASES        = 10;
  localparam int unsigned PHASE_TICKS   = 70;

  localparam logic [ispm_pkg::FEAT_W-1:0] CHECK_NONE     = '0;
  localparam logic [ispm_pkg::FEAT_W-1:0] CHECK_PRESSURE =
    ispm_pkg::FEAT_W'(1 << ispm_pkg::FEAT_PRESSURE);
  localparam logic [ispm_pkg::FEAT_W-1:0] CHECK_VALVE    =
    ispm_pkg::FEAT_W'(1 << ispm_pkg::FEAT_VALVE);

  typedef struct packed {
    logic                         heavy_active;
    logic                         light_active;
    logic [ispm_pkg::WORD_W-1:0]  heavy_fired;
    logic [ispm_pkg::WORD_W-1:0]  light_fired;
    logic [ispm_pkg::COUNT_W-1:0] heavy_count;
    logic [ispm_pkg::COUNT_W-1:0] light_count;
    logic                         pressure_error;
    logic                         valve_alarm;
  } tick_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           cfg_we    = 1'b0;
  logic [ispm_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [ispm_pkg::WORD_W-1:0]    cfg_data  = '0;

  logic                        in_valid          = 1'b0;
  logic                        in_ready;
  logic [ispm_pkg::WORD_W-1:0] sensor_bits       = '0;
  logic [ispm_pkg::WORD_W-1:0] diff_pressure     = '0;
  logic                        valves_all_closed = 1'b0;

  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         heavy_active;
  logic                         light_active;
  logic [ispm_pkg::WORD_W-1:0]  heavy_fired;
  logic [ispm_pkg::WORD_W-1:0]  light_fired;
  logic [ispm_pkg::COUNT_W-1:0] heavy_count;
  logic [ispm_pkg::COUNT_W-1:0] light_count;
  logic                         pressure_error;
  logic                         valve_alarm;

  // Register copies held by the predictor
  logic [ispm_pkg::MODE_W-1:0] cfg_mode       = ispm_pkg::MODE_DISABLED;
  logic                        cfg_all_enable = 1'b0;
  logic [ispm_pkg::WORD_W-1:0] cfg_check      = ispm_pkg::CHECK_TICKS_RESET;
  logic [ispm_pkg::WORD_W-1:0] cfg_enable     = '0;
  logic [ispm_pkg::WORD_W-1:0] cfg_normal     = '0;
  logic [ispm_pkg::WORD_W-1:0] cfg_heavy      = '0;
  logic [ispm_pkg::WORD_W-1:0] cfg_plimit     = '0;
  logic [ispm_pkg::FEAT_W-1:0] cfg_feat       = CHECK_NONE;

  // Monitor state held by the predictor
  logic                        timer_armed [ispm_pkg::MASK_BITS];
  logic [ispm_pkg::WORD_W-1:0] timer_ticks [ispm_pkg::MASK_BITS];
  logic              heavy_latch    = 1'b0;
  logic              light_latch    = 1'b0;
  logic              pressure_latch = 1'b0;

  tick_report_t expected_ticks[$];
  tick_report_t expected_head;

  bit          gaps_on          = 1'b1;
  bit          stalls_on        = 1'b1;
  bit          hold_off_request = 1'b0;
  int unsigned hold_left        = 0;
  int unsigned cycle_count      = 0;
  int unsigned mismatches       = 0;
  int unsigned ticks_sent       = 0;
  int unsigned results_checked  = 0;
  int unsigned settings_applied = 0;

  interlock_sensor_persistence_monitor_unit uut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .sensor_bits       (sensor_bits),
    .diff_pressure     (diff_pressure),
    .valves_all_closed (valves_all_closed),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .heavy_active      (heavy_active),
    .light_active      (light_active),
    .heavy_fired       (heavy_fired),
    .light_fired       (light_fired),
    .heavy_count       (heavy_count),
    .light_count       (light_count),
    .pressure_error    (pressure_error),
    .valve_alarm       (valve_alarm)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < ispm_pkg::MASK_BITS; i++) begin
      timer_armed[i] = 1'b0;
      timer_ticks[i] = '0;
    end
  end

  // Mostly short idle spans, now and then a long one
  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ispm_pkg::COUNT_W-1:0] count_up(
      input logic [ispm_pkg::COUNT_W-1:0] c);
    return (c < ispm_pkg::COUNT_MAX) ? c + 1'b1 : c;
  endfunction

  // Advance the predicted monitor by one tick and return the expected report
  function automatic tick_report_t advance_monitor(input logic [ispm_pkg::WORD_W-1:0] levels,
                                                   input logic [ispm_pkg::WORD_W-1:0] press,
                                                   input logic closed);
    tick_report_t r;
    logic gated;
    logic masked;
    logic low;
    r = '0;
    gated = (cfg_mode == ispm_pkg::MODE_DISABLED) ||
            (cfg_mode == ispm_pkg::MODE_CONTROL && !cfg_all_enable);
    if (gated) begin
      heavy_latch = 1'b0;
      light_latch = 1'b0;
      for (int i = 0; i < ispm_pkg::MASK_BITS; i++) begin
        timer_armed[i] = 1'b0;
        timer_ticks[i] = '0;
      end
    end else begin
      masked = (cfg_mode == ispm_pkg::MODE_CONTROL) || (cfg_mode == ispm_pkg::MODE_ENABLE);
      for (int i = 0; i < ispm_pkg::MASK_BITS; i++) begin
        // hold the timer of a sensor that is masked out
        if (masked && !cfg_enable[i]) continue;
        if (levels[i] == cfg_normal[i]) begin
          timer_armed[i] = 1'b0;
          timer_ticks[i] = '0;
          continue;
        end
        if (!timer_armed[i]) begin
          timer_armed[i] = 1'b1;
          timer_ticks[i] = '0;
        end else if (timer_ticks[i] != ispm_pkg::TICK_MAX) begin
          timer_ticks[i] = timer_ticks[i] + 1'b1;
        end
        if (timer_ticks[i] < cfg_check) continue;
        // fire and re-arm
        timer_armed[i] = 1'b0;
        timer_ticks[i] = '0;
        if (cfg_heavy[i]) begin
          r.heavy_fired[i] = 1'b1;
          r.heavy_count    = count_up(r.heavy_count);
        end else begin
          r.light_fired[i] = 1'b1;
          r.light_count    = count_up(r.light_count);
        end
      end
      if (cfg_feat[ispm_pkg::FEAT_PRESSURE]) begin
        low = (cfg_plimit > ispm_pkg::PRESSURE_MIN_LIMIT) && (press < cfg_plimit);
        if (low) r.heavy_count = count_up(r.heavy_count);
        pressure_latch = low;
      end
      if (cfg_feat[ispm_pkg::FEAT_VALVE] && closed) begin
        r.valve_alarm = 1'b1;
        r.heavy_count = count_up(r.heavy_count);
      end
      if (r.heavy_count != 0) heavy_latch = 1'b1;
      if (r.light_count != 0) light_latch = 1'b1;
      if (r.heavy_count == 0 && r.light_count == 0) begin
        heavy_latch = 1'b0;
        light_latch = 1'b0;
      end
    end
    r.heavy_active   = heavy_latch;
    r.light_active   = light_latch;
    r.pressure_error = pressure_latch;
    return r;
  endfunction

  // Offer one tick request, wait for it to be taken, then idle for a random span when gaps are on
  task automatic offer_tick(input logic [ispm_pkg::WORD_W-1:0] levels,
                            input logic [ispm_pkg::WORD_W-1:0] press,
                            input logic closed);
    int unsigned gap;
    in_valid          <= 1'b1;
    sensor_bits       <= levels;
    diff_pressure     <= press;
    valves_all_closed <= closed;
    do @(posedge clk); while (!in_ready);
    expected_ticks.push_back(advance_monitor(levels, press, closed));
    ticks_sent++;
    gap = gaps_on ? idle_span() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering, wait for every outstanding report, then let the pipe empty
  task automatic drain_monitor();
    in_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ispm_pkg::REG_IDX_W-1:0] idx,
                           input logic [ispm_pkg::WORD_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      ispm_pkg::REG_USE_MODE:     cfg_mode       = value[ispm_pkg::MODE_W-1:0];
      ispm_pkg::REG_SENSORS_ALL:  cfg_all_enable = value[0];
      ispm_pkg::REG_CHECK_TICKS:  cfg_check      = value;
      ispm_pkg::REG_ENABLE_MASK:  cfg_enable     = value;
      ispm_pkg::REG_NORMAL_MASK:  cfg_normal     = value;
      ispm_pkg::REG_HEAVY_MASK:   cfg_heavy      = value;
      ispm_pkg::REG_PRESSURE_LIM: cfg_plimit     = value;
      ispm_pkg::REG_FEATURES:     cfg_feat       = value[ispm_pkg::FEAT_W-1:0];
      default: ;
    endcase
  endtask

  // Drain, then write the whole register set
  task automatic configure(input logic [ispm_pkg::MODE_W-1:0] mode, input logic all_en,
                           input logic [ispm_pkg::WORD_W-1:0] check,
                           input logic [ispm_pkg::WORD_W-1:0] enable,
                           input logic [ispm_pkg::WORD_W-1:0] normal,
                           input logic [ispm_pkg::WORD_W-1:0] heavy,
                           input logic [ispm_pkg::WORD_W-1:0] limit,
                           input logic [ispm_pkg::FEAT_W-1:0] feat);
    drain_monitor();
    write_reg(ispm_pkg::REG_USE_MODE, ispm_pkg::WORD_W'(mode));
    write_reg(ispm_pkg::REG_SENSORS_ALL, ispm_pkg::WORD_W'(all_en));
    write_reg(ispm_pkg::REG_CHECK_TICKS, check);
    write_reg(ispm_pkg::REG_ENABLE_MASK, enable);
    write_reg(ispm_pkg::REG_NORMAL_MASK, normal);
    write_reg(ispm_pkg::REG_HEAVY_MASK, heavy);
    write_reg(ispm_pkg::REG_PRESSURE_LIM, limit);
    write_reg(ispm_pkg::REG_FEATURES, ispm_pkg::WORD_W'(feat));
    settings_applied++;
  endtask

  task automatic test_disabled_after_reset();
    offer_tick(16'hFFFF, 16'h0000, 1'b1);
    offer_tick(16'h0000, 16'hFFFF, 1'b0);
  endtask

  task automatic test_mode_gating();
    configure(ispm_pkg::MODE_CONTROL, 1'b0, 16'd0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'd0,
              CHECK_NONE);
    offer_tick(16'hFFFF, 16'd0, 1'b0);
    configure(ispm_pkg::MODE_CONTROL, 1'b1, 16'd0, 16'h00F0, 16'h0000, 16'h0030, 16'd0,
              CHECK_NONE);
    offer_tick(16'hFFFF, 16'd0, 1'b0);
    configure(ispm_pkg::MODE_ENABLE, 1'b0, 16'd0, 16'hF00F, 16'h0000, 16'hF000, 16'd0,
              CHECK_NONE);
    offer_tick(16'hFFFF, 16'd0, 1'b0);
  endtask

  task automatic test_persistence();
    configure(ispm_pkg::MODE_ALL, 1'b1, 16'd2, 16'h0000, 16'hA5A5, 16'h0F0F, 16'd0,
              CHECK_NONE);
    offer_tick(16'hA5A5, 16'd0, 1'b0);
    // hold two sensors off normal past the check time, then one tick more
    repeat (4) offer_tick(16'hA5A5 ^ 16'h8001, 16'd0, 1'b0);
    offer_tick(16'hA5A5, 16'd0, 1'b0);
    // every sensor off at once
    repeat (3) offer_tick(16'h5A5A, 16'd0, 1'b0);
    // zero check time fires on the arming tick; a light-only tick keeps heavy
    configure(ispm_pkg::MODE_ALL, 1'b1, 16'd0, 16'h0000, 16'hA5A5, 16'h0F0F, 16'd0,
              CHECK_NONE);
    offer_tick(16'h5A5A, 16'd0, 1'b0);
    offer_tick(16'hA5A5 ^ 16'h0010, 16'd0, 1'b0);
    offer_tick(16'hA5A5, 16'd0, 1'b0);
  endtask

  task automatic test_pressure_and_valve();
    configure(ispm_pkg::MODE_ALL, 1'b1, 16'd10, 16'h0000, 16'h0000, 16'h0000, 16'd2,
              CHECK_PRESSURE);
    offer_tick(16'h0000, 16'd1, 1'b0);
    offer_tick(16'h0000, 16'd2, 1'b0);
    configure(ispm_pkg::MODE_ALL, 1'b1, 16'd10, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
              CHECK_PRESSURE);
    offer_tick(16'h0000, 16'h0000, 1'b0);
    offer_tick(16'h0000, 16'hFFFF, 1'b0);
    offer_tick(16'h0000, 16'hFFFE, 1'b0);
    // flag holds with the check absent and through a disabled mode
    configure(ispm_pkg::MODE_ALL, 1'b1, 16'd10, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
              CHECK_NONE);
    offer_tick(16'h0000, 16'hFFFF, 1'b0);
    configure(ispm_pkg::MODE_DISABLED, 1'b1, 16'd10, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
              CHECK_PRESSURE);
    offer_tick(16'hFFFF, 16'h0000, 1'b1);
    // a limit of one or less clears the flag
    configure(ispm_pkg::MODE_ALL, 1'b1, 16'd10, 16'h0000, 16'h0000, 16'h0000, 16'd1,
              CHECK_PRESSURE);
    offer_tick(16'h0000, 16'h0000, 1'b0);
    configure(ispm_pkg::MODE_ALL, 1'b1, 16'd10, 16'h0000, 16'h0000, 16'h0000, 16'd0,
              CHECK_PRESSURE | CHECK_VALVE);
    offer_tick(16'h0000, 16'h0000, 1'b1);
  endtask

  // Draw a register set; the first two phases pin the check time to its extremes
  task automatic random_setting(input int unsigned phase);
    logic [ispm_pkg::MODE_W-1:0] mode;
    logic [ispm_pkg::WORD_W-1:0] check;
    logic [ispm_pkg::WORD_W-1:0] enable;
    logic [ispm_pkg::WORD_W-1:0] limit;
    int unsigned r;
    r = $urandom_range(0, 9);
    mode = (r == 0) ? ispm_pkg::MODE_DISABLED :
           (r < 4)  ? ispm_pkg::MODE_CONTROL :
           (r < 7)  ? ispm_pkg::MODE_ENABLE : ispm_pkg::MODE_ALL;
    r = $urandom_range(0, 9);
    check = (r < 7) ? ispm_pkg::WORD_W'($urandom_range(0, 4)) :
            (r < 9) ? ispm_pkg::WORD_W'($urandom_range(5, 20)) : ispm_pkg::WORD_W'($urandom);
    r = $urandom_range(0, 9);
    enable = (r == 0) ? 16'hFFFF : (r == 1) ? 16'h0000 : ispm_pkg::WORD_W'($urandom);
    r = $urandom_range(0, 9);
    limit = (r < 2) ? ispm_pkg::WORD_W'($urandom_range(0, 1)) :
            (r < 8) ? ispm_pkg::WORD_W'($urandom_range(2, 40)) : ispm_pkg::WORD_W'($urandom);
    if (phase == 0) begin
      mode  = ispm_pkg::MODE_ALL;
      check = 16'd0;
    end
    if (phase == 1) check = ispm_pkg::TICK_MAX;
    configure(mode, $urandom_range(0, 4) != 0, check, enable, ispm_pkg::WORD_W'($urandom),
              ispm_pkg::WORD_W'($urandom), limit, ispm_pkg::FEAT_W'($urandom));
  endtask

  // Mostly sensors drifting off and back to normal, the rest pure noise
  task automatic run_random_ticks(input int unsigned count);
    logic [ispm_pkg::WORD_W-1:0] off_pattern;
    logic [ispm_pkg::WORD_W-1:0] levels;
    logic [ispm_pkg::WORD_W-1:0] press;
    off_pattern = '0;
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 85) begin
        off_pattern = off_pattern ^ (ispm_pkg::WORD_W'($urandom) &
                                     ispm_pkg::WORD_W'($urandom) &
                                     ispm_pkg::WORD_W'($urandom));
        levels = cfg_normal ^ off_pattern;
      end else begin
        levels = ispm_pkg::WORD_W'($urandom);
      end
      if ($urandom_range(0, 3) == 0) press = ispm_pkg::WORD_W'($urandom);
      else press = ispm_pkg::WORD_W'($urandom_range(0, 32'(cfg_plimit) + 3));
      offer_tick(levels, press, $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic test_random_settings();
    for (int unsigned p = 0; p < PHASES; p++) begin
      random_setting(p);
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      run_random_ticks(PHASE_TICKS);
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_backpressure();
    configure(ispm_pkg::MODE_ALL, 1'b1, 16'd1, 16'h0000, 16'h0000, 16'h00FF, 16'd20,
              CHECK_PRESSURE | CHECK_VALVE);
    // keep offering back to back while the output is held off
    gaps_on          = 1'b0;
    hold_off_request = 1'b1;
    run_random_ticks(16);
    // pause until every report is back, then resume with gaps
    drain_monitor();
    gaps_on = 1'b1;
    run_random_ticks(16);
  endtask

  // Output side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_off_request) begin
      hold_off_request = 1'b0;
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
    end else if (stalls_on && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      hold_left <= idle_span();
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic compare_field(input string what, input logic [ispm_pkg::WORD_W-1:0] want,
                               input logic [ispm_pkg::WORD_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, what, want, got);
    end
  endtask

  // Compare each report with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_ticks.size() == 0) begin
        mismatches++;
        $display("%0t: report with no tick outstanding, expected none, actual %h %h",
                 $time, heavy_fired, light_fired);
      end else begin
        expected_head = expected_ticks.pop_front();
        results_checked++;
        compare_field("heavy_active", ispm_pkg::WORD_W'(expected_head.heavy_active),
                      ispm_pkg::WORD_W'(heavy_active));
        compare_field("light_active", ispm_pkg::WORD_W'(expected_head.light_active),
                      ispm_pkg::WORD_W'(light_active));
        compare_field("heavy_fired", expected_head.heavy_fired, heavy_fired);
        compare_field("light_fired", expected_head.light_fired, light_fired);
        compare_field("heavy_count", ispm_pkg::WORD_W'(expected_head.heavy_count),
                      ispm_pkg::WORD_W'(heavy_count));
        compare_field("light_count", ispm_pkg::WORD_W'(expected_head.light_count),
                      ispm_pkg::WORD_W'(light_count));
        compare_field("pressure_error", ispm_pkg::WORD_W'(expected_head.pressure_error),
                      ispm_pkg::WORD_W'(pressure_error));
        compare_field("valve_alarm", ispm_pkg::WORD_W'(expected_head.valve_alarm),
                      ispm_pkg::WORD_W'(valve_alarm));
      end
    end
  end

  // Abandon a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_disabled_after_reset();
    test_mode_gating();
    test_persistence();
    test_pressure_and_valve();
    test_random_settings();
    test_backpressure();
    drain_monitor();
    $display("%0d ticks checked in %0d reports over %0d register settings",
             ticks_sent, results_checked, settings_applied);
    $display("all modes, zero and full-scale check times, pressure, valve, long output hold");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
